// ===== rtl/core/agpc_pkg.sv =====
// Shared constants and elaboration-time helpers for the alpha gamma pixel corrector.
// No dependencies; imported by agpc_pow and alpha_gamma_pixel_correct.
`timescale 1ns / 1ps
`default_nettype none

package agpc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int FB_MIN        = 10;
    localparam int FB_MAX        = 24;

    // Bits of -log2 resolved by squaring, and table length of the exp stages
    localparam int LOG_STEPS = 24;

    // Depth of one power unit, the sum of its normalize, log, scale, exp and out stages
    localparam int POW_LAT = 3 + LOG_STEPS + 2 + LOG_STEPS + 2;

    // Reciprocals for exact floor division: m/5 with m < 2^29 (shift 32),
    // v/11 with v < 2^32 (shift 36)
    localparam logic [63:0] R5  = 64'd858993460;
    localparam logic [63:0] R11 = 64'd6247225158;

    // Payload kept beside the datapath for pass-through pixels
    typedef struct packed {
        logic       pass;
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_side;

    function automatic int f_clamp_fb(input int v);
        int r;
        r = v;
        if (r < FB_MIN) r = FB_MIN;
        if (r > FB_MAX) r = FB_MAX;
        return r;
    endfunction

    function automatic logic [63:0] f_isqrt64(input logic [63:0] val);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = val;
        root = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // 2^(2^-j) in Q2.30, built by repeated integer square roots of 2.0
    function automatic logic [63:0] f_exp_tab(input int j);
        logic [63:0] t;
        t = 64'd2 << 30;
        for (int i = 1; i <= j; i++) begin
            t = f_isqrt64(t << 30);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/alpha_gamma_pixel_correct.sv =====
// Gamma-2.2 alpha correction of premultiplied BGRA pixels; uses agpc_pkg, agpc_pow.
// Throughput: one item per cycle while no result waits blocked at the output; the depth
// comes from two chained power units (log by squaring, exp by table products) and the
// restoring divider. Reset (synchronous, active low) clears the valid line only; the whole
// pipe stalls together while a result waits at the output.
`timescale 1ns / 1ps
`default_nettype none

module alpha_gamma_pixel_correct
    import agpc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // blue_in, green_in, red_in, alpha_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // blue_out, green_out, red_out, alpha_out
);

    localparam int FB    = f_clamp_fb(FRAC_BITS);
    localparam int W_D   = FB + 8;          // dividend: channel << FB plus alpha/2
    localparam int PW    = 2 * FB + 3;      // product width
    localparam logic [FB:0] ONE  = {1'b1, {FB{1'b0}}};
    localparam logic [FB:0] HALF = ONE >> 1;
    localparam logic [63:0] K3_64 = (64'd3333 * (64'd1 << FB) + 64'd5000) / 64'd10000;
    localparam logic [FB-1:0] K3 = FB'(K3_64);

    // stage positions, counted in enabled cycles after acceptance
    localparam int I_U   = FB + 3;          // quotient ready
    localparam int I_LIN = I_U + POW_LAT;   // linear channels ready
    localparam int I_FG  = I_LIN + 2;       // mean ready
    localparam int I_PD  = I_FG + POW_LAT;  // re-encoded values ready
    localparam int LAT   = I_PD + 4;        // output register
    localparam int A_DLY = I_FG - 2;

    // global advance: everything moves unless a result is held at the output
    logic w_en;
    logic [LAT-1:0] r_vld;
    t_side r_side [LAT-1];

    assign w_en          = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0].blue  <= s_axis_tdata[7:0];
            r_side[0].green <= s_axis_tdata[15:8];
            r_side[0].red   <= s_axis_tdata[23:16];
            r_side[0].alpha <= s_axis_tdata[31:24];
            r_side[0].pass  <= (s_axis_tdata[31:24] == 8'd0)
                            || (s_axis_tdata[31:24] == 8'd255);
            for (int i = 1; i < LAT - 1; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // ---- prep: clamp channel to alpha, build dividend, look up a ----
    logic [FB:0]    w_a_lut [256];
    logic [7:0]     w_ch    [3];
    logic [W_D-1:0] n_pd    [3];
    logic [W_D-1:0] r_pd    [3];
    logic [7:0]     r_palpha;
    logic [FB:0]    r_a;

    generate
        for (genvar g = 0; g < 256; g++) begin : g_alut
            assign w_a_lut[g] = (FB+1)'(((64'(g) << FB) + 64'd127) / 64'd255);
        end
    endgenerate

    assign w_ch[0] = r_side[0].blue;
    assign w_ch[1] = r_side[0].green;
    assign w_ch[2] = r_side[0].red;

    always_comb begin
        logic [7:0] cc;
        for (int c = 0; c < 3; c++) begin
            cc      = (w_ch[c] > r_side[0].alpha) ? r_side[0].alpha : w_ch[c];
            n_pd[c] = (W_D'(cc) << FB) + W_D'(r_side[0].alpha[7:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pd     <= n_pd;
            r_palpha <= r_side[0].alpha;
            r_a      <= w_a_lut[r_side[0].alpha];
        end
    end

    // ---- restoring divider, one quotient bit per stage, MSB first ----
    logic [W_D-1:0] r_dv  [3][FB+1];
    logic [7:0]     r_rem [3][FB+1];
    logic [FB:0]    r_q   [3][FB+1];
    logic [7:0]     r_dal [FB+1];
    logic [W_D-1:0] n_dv  [3][FB+1];
    logic [7:0]     n_rem [3][FB+1];
    logic [FB:0]    n_q   [3][FB+1];
    logic [7:0]     n_dal [FB+1];

    always_comb begin
        logic [7:0]     rin;
        logic [W_D-1:0] dv;
        logic [7:0]     al;
        logic [FB:0]    qin;
        logic [8:0]     t;
        for (int s = 0; s <= FB; s++) begin
            n_dal[s] = (s == 0) ? r_palpha : r_dal[(s == 0) ? 0 : s - 1];
        end
        for (int c = 0; c < 3; c++) begin
            for (int s = 0; s <= FB; s++) begin
                if (s == 0) begin
                    rin = {1'b0, r_pd[c][W_D-1:FB+1]};
                    dv  = r_pd[c];
                    al  = r_palpha;
                    qin = '0;
                end else begin
                    rin = r_rem[c][s-1];
                    dv  = r_dv[c][s-1];
                    al  = r_dal[s-1];
                    qin = r_q[c][s-1];
                end
                t = {rin, dv[FB-s]};
                if (t >= {1'b0, al}) begin
                    n_rem[c][s] = 8'(t - {1'b0, al});
                    n_q[c][s]   = qin | ((FB+1)'(1) << (FB - s));
                end else begin
                    n_rem[c][s] = t[7:0];
                    n_q[c][s]   = qin;
                end
                n_dv[c][s] = dv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv  <= n_dv;
            r_rem <= n_rem;
            r_q   <= n_q;
            r_dal <= n_dal;
        end
    end

    // ---- linearize: u^(11/5) per channel ----
    logic [FB:0] w_lin [3];

    generate
        for (genvar c = 0; c < 3; c++) begin : g_lin
            agpc_pow #(.FB(FB), .UP(1'b1)) u_pow_lin (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_x   (r_q[c][FB]),
                .o_y   (w_lin[c])
            );
        end
    endgenerate

    // ---- weighted mean of the linear channels ----
    logic [FB+1:0] r_sum;
    logic [PW-1:0] w_fgp;
    logic [PW-1:0] w_fgs;
    logic [FB:0]   r_fg;
    logic [FB:0]   r_lin_d [3][2];
    logic [FB:0]   r_a_dly [A_DLY];

    assign w_fgp = PW'(K3) * PW'(r_sum) + PW'(HALF);
    assign w_fgs = w_fgp >> FB;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= (FB+2)'(w_lin[0]) + (FB+2)'(w_lin[1]) + (FB+2)'(w_lin[2]);
            r_fg  <= (w_fgs > PW'(ONE)) ? ONE : w_fgs[FB:0];
            for (int c = 0; c < 3; c++) begin
                r_lin_d[c][0] <= w_lin[c];
                r_lin_d[c][1] <= r_lin_d[c][0];
            end
            r_a_dly[0] <= r_a;
            for (int i = 1; i < A_DLY; i++) begin
                r_a_dly[i] <= r_a_dly[i-1];
            end
        end
    end

    // ---- re-encode: ^(5/11) of black, white, mix and the three channels ----
    logic [FB:0] w_pb;
    logic [FB:0] w_pw;
    logic [FB:0] w_pm;
    logic [FB:0] w_pe [3];
    logic [FB:0] w_1ma;

    assign w_1ma = ONE - r_a_dly[A_DLY-1];

    agpc_pow #(.FB(FB), .UP(1'b0)) u_pow_black (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_1ma),
        .o_y   (w_pb)
    );

    agpc_pow #(.FB(FB), .UP(1'b0)) u_pow_white (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_a_dly[A_DLY-1]),
        .o_y   (w_pw)
    );

    agpc_pow #(.FB(FB), .UP(1'b0)) u_pow_mix (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_fg),
        .o_y   (w_pm)
    );

    generate
        for (genvar c = 0; c < 3; c++) begin : g_enc
            agpc_pow #(.FB(FB), .UP(1'b0)) u_pow_enc (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_x   (r_lin_d[c][1]),
                .o_y   (w_pe[c])
            );
        end
    endgenerate

    // ---- corrected alpha = (1-black)*(1-mix) + white*mix ----
    logic [PW-1:0] r_p1;
    logic [PW-1:0] r_p2;
    logic [PW-1:0] w_cs;
    logic [FB:0]   r_corr;
    logic [FB:0]   r_corr_d;
    logic [FB:0]   r_enc_d [3][2];
    logic [FB:0]   w_mq [3];
    logic [FB:0]   r_m  [3];

    assign w_cs = (r_p1 + r_p2 + PW'(HALF)) >> FB;

    always_comb begin
        logic [PW-1:0] t;
        for (int c = 0; c < 3; c++) begin
            t       = (PW'(r_enc_d[c][1]) * PW'(r_corr) + PW'(HALF)) >> FB;
            w_mq[c] = t[FB:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1     <= PW'(ONE - w_pb) * PW'(ONE - w_pm);
            r_p2     <= PW'(w_pw) * PW'(w_pm);
            r_corr   <= (w_cs > PW'(ONE)) ? ONE : w_cs[FB:0];
            r_corr_d <= r_corr;
            for (int c = 0; c < 3; c++) begin
                r_enc_d[c][0] <= w_pe[c];
                r_enc_d[c][1] <= r_enc_d[c][0];
                r_m[c]        <= w_mq[c];
            end
        end
    end

    // ---- bytes and output register ----
    function automatic logic [7:0] f_byte(input logic [FB:0] v);
        logic [FB+9:0] t;
        t = ((FB+10)'(v) << 8) - (FB+10)'(v) + (FB+10)'(HALF);
        t = t >> FB;
        return (t > (FB+10)'(255)) ? 8'hFF : t[7:0];
    endfunction

    t_side       w_sd;
    logic [31:0] n_out;
    logic [31:0] r_out;

    assign w_sd = r_side[LAT-2];

    always_comb begin
        if (w_sd.pass) begin
            n_out = {w_sd.alpha, w_sd.red, w_sd.green, w_sd.blue};
        end else begin
            n_out = {f_byte(r_corr_d), f_byte(r_m[2]), f_byte(r_m[1]), f_byte(r_m[0])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_vld[LAT-1];
    assign m_axis_tdata  = r_out;

    // ---- checks ----
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid line moved during a stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted item missing from the valid line");

    a_blocked_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while the output is blocked");

endmodule

`default_nettype wire

// ===== rtl/core/agpc_pow.sv =====
// Pipelined fixed-point power unit: x^(11/5) or x^(5/11) for x in [0, 1] in Q.FB.
// Uses agpc_pkg (stage counts, reciprocals, exp table builder).
`timescale 1ns / 1ps
`default_nettype none

module agpc_pow
    import agpc_pkg::*;
#(
    parameter int FB = FRAC_BITS_DEF,
    parameter bit UP = 1'b1
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [FB:0] i_x,
    output logic [FB:0] o_y
);

    localparam logic [FB:0]   ONE   = {1'b1, {FB{1'b0}}};
    localparam logic [30:0]   P_ONE = {1'b1, 30'b0};
    localparam logic [31:0]   HALF  = 32'd1 << (29 - FB);
    localparam int            MW    = 5 + LOG_STEPS;

    // normalize
    logic [FB:0] r0_x;
    logic        r0_z;
    logic [4:0]  w1_msb;
    logic [FB:0] r1_x;
    logic [4:0]  r1_sh;
    logic [4:0]  r1_e;
    logic        r1_z;
    logic [30:0] r2_y;
    logic [4:0]  r2_e;
    logic        r2_z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_x <= (i_x > ONE) ? ONE : i_x;
            r0_z <= (i_x == '0);
        end
    end

    always_comb begin
        w1_msb = '0;
        for (int i = 0; i <= FB; i++) begin
            if (r0_x[i]) w1_msb = 5'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x  <= r0_x;
            r1_sh <= 5'd30 - w1_msb;
            r1_e  <= 5'(FB) - w1_msb;
            r1_z  <= r0_z;
            r2_y  <= 31'(r1_x) << r1_sh;
            r2_e  <= r1_e;
            r2_z  <= r1_z;
        end
    end

    // -log2 fraction: one squaring per stage
    logic [30:0]          r_y  [LOG_STEPS];
    logic [LOG_STEPS-1:0] r_fr [LOG_STEPS];
    logic [4:0]           r_e  [LOG_STEPS];
    logic                 r_lz [LOG_STEPS];
    logic [30:0]          n_y  [LOG_STEPS];
    logic [LOG_STEPS-1:0] n_fr [LOG_STEPS];

    always_comb begin
        logic [30:0]          yin;
        logic [LOG_STEPS-1:0] fin;
        logic [61:0]          sq;
        logic [31:0]          t;
        for (int i = 0; i < LOG_STEPS; i++) begin
            if (i == 0) begin
                yin = r2_y;
                fin = '0;
            end else begin
                yin = r_y[i-1];
                fin = r_fr[i-1];
            end
            sq = {31'b0, yin} * {31'b0, yin};
            t  = sq[61:30];
            if (t[31]) begin
                n_y[i]  = t[31:1];
                n_fr[i] = {fin[LOG_STEPS-2:0], 1'b1};
            end else begin
                n_y[i]  = t[30:0];
                n_fr[i] = {fin[LOG_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < LOG_STEPS; i++) begin
                r_y[i]  <= n_y[i];
                r_fr[i] <= n_fr[i];
                r_e[i]  <= (i == 0) ? r2_e : r_e[(i == 0) ? 0 : i - 1];
                r_lz[i] <= (i == 0) ? r2_z : r_lz[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // scale the log by the exponent
    logic [MW-1:0] w_m;
    logic [31:0]   n_v;
    logic [31:0]   rM_v;
    logic          rM_z;
    logic [30:0]   w_mp;
    logic [6:0]    rQ_k;
    logic          rQ_fz;
    logic [LOG_STEPS-1:0] rQ_g;
    logic          rQ_z;

    assign w_m = {r_e[LOG_STEPS-1], {LOG_STEPS{1'b0}}}
               - MW'(r_fr[LOG_STEPS-1]);
    assign n_v = UP ? 32'(w_m) : (32'({w_m, 2'b00}) + 32'(w_m));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rM_v <= n_v;
            rM_z <= r_lz[LOG_STEPS-1];
        end
    end

    generate
        if (UP) begin : g_up
            logic [63:0] w_p5;
            assign w_p5 = 64'(rM_v) * R5;
            assign w_mp = 31'({rM_v, 1'b0}) + 31'(w_p5 >> 32);
        end else begin : g_dn
            logic [64:0] w_p11;
            assign w_p11 = 65'(rM_v) * 65'(R11);
            assign w_mp  = 31'(w_p11 >> 36);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rQ_k  <= w_mp[30:24];
            rQ_fz <= (w_mp[LOG_STEPS-1:0] == '0);
            rQ_g  <= LOG_STEPS'(0) - w_mp[LOG_STEPS-1:0];
            rQ_z  <= rM_z;
        end
    end

    // 2^-frac as a product of table entries, one entry per stage
    logic [30:0]          r_p   [LOG_STEPS];
    logic [LOG_STEPS-1:0] r_xg  [LOG_STEPS];
    logic [6:0]           r_xk  [LOG_STEPS];
    logic                 r_xfz [LOG_STEPS];
    logic                 r_xz  [LOG_STEPS];

    generate
        for (genvar jj = 0; jj < LOG_STEPS; jj++) begin : g_exp
            localparam logic [30:0] TABJ = 31'(f_exp_tab(jj + 1));
            logic [30:0]          w_pin;
            logic [LOG_STEPS-1:0] w_gin;
            logic [6:0]           w_kin;
            logic                 w_fzin;
            logic                 w_zin;
            logic [61:0]          w_pp;
            if (jj == 0) begin : g_first
                assign w_pin  = P_ONE;
                assign w_gin  = rQ_g;
                assign w_kin  = rQ_k;
                assign w_fzin = rQ_fz;
                assign w_zin  = rQ_z;
            end else begin : g_next
                assign w_pin  = r_p[jj-1];
                assign w_gin  = r_xg[jj-1];
                assign w_kin  = r_xk[jj-1];
                assign w_fzin = r_xfz[jj-1];
                assign w_zin  = r_xz[jj-1];
            end
            assign w_pp = {31'b0, w_pin} * {31'b0, TABJ};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_p[jj]   <= w_gin[LOG_STEPS-1-jj] ? w_pp[60:30] : w_pin;
                    r_xg[jj]  <= w_gin;
                    r_xk[jj]  <= w_kin;
                    r_xfz[jj] <= w_fzin;
                    r_xz[jj]  <= w_zin;
                end
            end
        end
    endgenerate

    // integer part shift, then round to Q.FB
    logic [30:0] w_r;
    logic [30:0] rR;
    logic        rR_z;
    logic [31:0] w_rnd;
    logic [FB:0] r_o;

    assign w_r = r_xfz[LOG_STEPS-1] ? P_ONE : {1'b0, r_p[LOG_STEPS-1][30:1]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rR   <= w_r >> r_xk[LOG_STEPS-1];
            rR_z <= r_xz[LOG_STEPS-1];
        end
    end

    assign w_rnd = (32'(rR) + HALF) >> (30 - FB);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (rR_z)                    r_o <= '0;
            else if (w_rnd > 32'(ONE))   r_o <= ONE;
            else                         r_o <= w_rnd[FB:0];
        end
    end

    assign o_y = r_o;

endmodule

`default_nettype wire
